// File: rtl/core/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// i2cseq_pkg
// shared types and status codes of the i2c register access sequencer
// ----------------------------------------------------------------------------
package i2cseq_pkg;

   // controller status codes, upper five bits of the status register
   localparam logic [7:0] STATUS_MASK     = 8'hF8;
   localparam logic [7:0] ST_START        = 8'h08;
   localparam logic [7:0] ST_REP_START    = 8'h10;
   localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
   localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
   localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_START = 2'd1,
      CMD_XFER  = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_type;

   // sub-step of a phase; capture is only meaningful in the receive phase
   typedef enum logic [1:0] {
      STEP_ISSUE   = 2'd0,
      STEP_WAIT    = 2'd1,
      STEP_CHECK   = 2'd2,
      STEP_CAPTURE = 2'd3
   } step_type;

   typedef enum logic [2:0] {
      WR_START = 3'd0,
      WR_SLA   = 3'd1,
      WR_REG   = 3'd2,
      WR_DATA  = 3'd3,
      WR_STOP  = 3'd4
   } wr_phase_type;

   typedef enum logic [2:0] {
      RD_START   = 3'd0,
      RD_SLA_W   = 3'd1,
      RD_REG     = 3'd2,
      RD_RESTART = 3'd3,
      RD_SLA_R   = 3'd4,
      RD_RECEIVE = 3'd5,
      RD_STOP    = 3'd6
   } rd_phase_type;

   typedef struct packed {
      wr_phase_type write_phase;
      rd_phase_type read_phase;
      step_type     start_step;
      step_type     restart_step;
      step_type     address_step;
      step_type     byte_step;
      step_type     receive_step;
      step_type     stop_step;
   } seq_state_type;

   typedef struct packed {
      logic       func;
      logic [7:0] slave_addr_byte;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
      logic       int_flag;
      logic       stop_pending;
      logic [7:0] status_reg;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      cmd_type    ctrl_cmd;
      logic       data_write_valid;
      logic [7:0] data_value;
      logic       done_res;
      logic       read_valid;
      logic [7:0] read_data;
   } rsp_type;

endpackage

// File: rtl/core/i2cseq_poll.sv
// ----------------------------------------------------------------------------
// i2cseq_poll
// one poll of the sequencer: next phase/sub-step state and the poll result
// ----------------------------------------------------------------------------
module i2cseq_poll (
   input  i2cseq_pkg::req_type       req,
   input  i2cseq_pkg::seq_state_type cur,
   output i2cseq_pkg::seq_state_type nxt,
   output i2cseq_pkg::rsp_type       rsp
);

   logic [7:0] status_code;
   logic [7:0] sla_read;

   // command / wait flag / compare status
   function automatic i2cseq_pkg::step_type byte_step_next(
      input i2cseq_pkg::step_type step,
      input logic                 flag,
      input logic                 match
   );
      i2cseq_pkg::step_type res;
      res = i2cseq_pkg::STEP_ISSUE;
      unique case (step)
         i2cseq_pkg::STEP_ISSUE: res = i2cseq_pkg::STEP_WAIT;
         i2cseq_pkg::STEP_WAIT:  res = flag ? i2cseq_pkg::STEP_CHECK : i2cseq_pkg::STEP_WAIT;
         i2cseq_pkg::STEP_CHECK: res = match ? i2cseq_pkg::STEP_ISSUE : i2cseq_pkg::STEP_CHECK;
         default:                res = i2cseq_pkg::STEP_ISSUE;
      endcase
      return res;
   endfunction

   function automatic logic byte_step_done(
      input i2cseq_pkg::step_type step,
      input logic                 match
   );
      return (step == i2cseq_pkg::STEP_CHECK) && match;
   endfunction

   assign status_code = req.status_reg & i2cseq_pkg::STATUS_MASK;
   assign sla_read    = req.slave_addr_byte + 8'd1;

   // next state
   always_comb begin
      nxt = cur;
      if (!req.func) begin
         unique case (cur.write_phase)
            i2cseq_pkg::WR_START: begin
               nxt.start_step = byte_step_next(cur.start_step, req.int_flag,
                                               status_code == i2cseq_pkg::ST_START);
               if (byte_step_done(cur.start_step, status_code == i2cseq_pkg::ST_START))
                  nxt.write_phase = i2cseq_pkg::WR_SLA;
            end
            i2cseq_pkg::WR_SLA: begin
               nxt.address_step = byte_step_next(cur.address_step, req.int_flag,
                                                 status_code == i2cseq_pkg::ST_MT_SLA_ACK);
               if (byte_step_done(cur.address_step, status_code == i2cseq_pkg::ST_MT_SLA_ACK))
                  nxt.write_phase = i2cseq_pkg::WR_REG;
            end
            i2cseq_pkg::WR_REG: begin
               nxt.byte_step = byte_step_next(cur.byte_step, req.int_flag,
                                              status_code == i2cseq_pkg::ST_MT_DATA_ACK);
               if (byte_step_done(cur.byte_step, status_code == i2cseq_pkg::ST_MT_DATA_ACK))
                  nxt.write_phase = i2cseq_pkg::WR_DATA;
            end
            i2cseq_pkg::WR_DATA: begin
               nxt.byte_step = byte_step_next(cur.byte_step, req.int_flag,
                                              status_code == i2cseq_pkg::ST_MT_DATA_ACK);
               if (byte_step_done(cur.byte_step, status_code == i2cseq_pkg::ST_MT_DATA_ACK))
                  nxt.write_phase = i2cseq_pkg::WR_STOP;
            end
            i2cseq_pkg::WR_STOP: begin
               unique case (cur.stop_step)
                  i2cseq_pkg::STEP_ISSUE: nxt.stop_step = i2cseq_pkg::STEP_WAIT;
                  i2cseq_pkg::STEP_WAIT: begin
                     if (!req.stop_pending) nxt.stop_step = i2cseq_pkg::STEP_CHECK;
                  end
                  i2cseq_pkg::STEP_CHECK: begin
                     nxt.stop_step   = i2cseq_pkg::STEP_ISSUE;
                     nxt.write_phase = i2cseq_pkg::WR_START;
                  end
                  default: nxt.stop_step = i2cseq_pkg::STEP_ISSUE;
               endcase
            end
            default: ;
         endcase
      end else begin
         unique case (cur.read_phase)
            i2cseq_pkg::RD_START: begin
               nxt.start_step = byte_step_next(cur.start_step, req.int_flag,
                                               status_code == i2cseq_pkg::ST_START);
               if (byte_step_done(cur.start_step, status_code == i2cseq_pkg::ST_START))
                  nxt.read_phase = i2cseq_pkg::RD_SLA_W;
            end
            i2cseq_pkg::RD_SLA_W: begin
               nxt.address_step = byte_step_next(cur.address_step, req.int_flag,
                                                 status_code == i2cseq_pkg::ST_MT_SLA_ACK);
               if (byte_step_done(cur.address_step, status_code == i2cseq_pkg::ST_MT_SLA_ACK))
                  nxt.read_phase = i2cseq_pkg::RD_REG;
            end
            i2cseq_pkg::RD_REG: begin
               nxt.byte_step = byte_step_next(cur.byte_step, req.int_flag,
                                              status_code == i2cseq_pkg::ST_MT_DATA_ACK);
               if (byte_step_done(cur.byte_step, status_code == i2cseq_pkg::ST_MT_DATA_ACK))
                  nxt.read_phase = i2cseq_pkg::RD_RESTART;
            end
            i2cseq_pkg::RD_RESTART: begin
               nxt.restart_step = byte_step_next(cur.restart_step, req.int_flag,
                                                 status_code == i2cseq_pkg::ST_REP_START);
               if (byte_step_done(cur.restart_step, status_code == i2cseq_pkg::ST_REP_START))
                  nxt.read_phase = i2cseq_pkg::RD_SLA_R;
            end
            i2cseq_pkg::RD_SLA_R: begin
               nxt.address_step = byte_step_next(cur.address_step, req.int_flag,
                                                 status_code == i2cseq_pkg::ST_MR_SLA_ACK);
               if (byte_step_done(cur.address_step, status_code == i2cseq_pkg::ST_MR_SLA_ACK))
                  nxt.read_phase = i2cseq_pkg::RD_RECEIVE;
            end
            i2cseq_pkg::RD_RECEIVE: begin
               unique case (cur.receive_step)
                  i2cseq_pkg::STEP_ISSUE: nxt.receive_step = i2cseq_pkg::STEP_WAIT;
                  i2cseq_pkg::STEP_WAIT: begin
                     if (req.int_flag) nxt.receive_step = i2cseq_pkg::STEP_CHECK;
                  end
                  i2cseq_pkg::STEP_CHECK: begin
                     if (status_code == i2cseq_pkg::ST_MR_DATA_NACK)
                        nxt.receive_step = i2cseq_pkg::STEP_CAPTURE;
                  end
                  default: begin
                     nxt.receive_step = i2cseq_pkg::STEP_ISSUE;
                     nxt.read_phase   = i2cseq_pkg::RD_STOP;
                  end
               endcase
            end
            i2cseq_pkg::RD_STOP: begin
               unique case (cur.stop_step)
                  i2cseq_pkg::STEP_ISSUE: nxt.stop_step = i2cseq_pkg::STEP_WAIT;
                  i2cseq_pkg::STEP_WAIT: begin
                     if (!req.stop_pending) nxt.stop_step = i2cseq_pkg::STEP_CHECK;
                  end
                  i2cseq_pkg::STEP_CHECK: begin
                     nxt.stop_step  = i2cseq_pkg::STEP_ISSUE;
                     nxt.read_phase = i2cseq_pkg::RD_START;
                  end
                  default: nxt.stop_step = i2cseq_pkg::STEP_ISSUE;
               endcase
            end
            default: ;
         endcase
      end
   end

   // poll result
   always_comb begin
      rsp = '0;
      if (!req.func) begin
         unique case (cur.write_phase)
            i2cseq_pkg::WR_START: begin
               if (cur.start_step == i2cseq_pkg::STEP_ISSUE) rsp.ctrl_cmd = i2cseq_pkg::CMD_START;
            end
            i2cseq_pkg::WR_SLA: begin
               rsp.data_write_valid = 1'b1;
               rsp.data_value       = req.slave_addr_byte;
               if (cur.address_step == i2cseq_pkg::STEP_ISSUE)
                  rsp.ctrl_cmd = i2cseq_pkg::CMD_XFER;
            end
            i2cseq_pkg::WR_REG: begin
               rsp.data_write_valid = 1'b1;
               rsp.data_value       = req.reg_addr;
               if (cur.byte_step == i2cseq_pkg::STEP_ISSUE) rsp.ctrl_cmd = i2cseq_pkg::CMD_XFER;
            end
            i2cseq_pkg::WR_DATA: begin
               rsp.data_write_valid = 1'b1;
               rsp.data_value       = req.write_data;
               if (cur.byte_step == i2cseq_pkg::STEP_ISSUE) rsp.ctrl_cmd = i2cseq_pkg::CMD_XFER;
            end
            i2cseq_pkg::WR_STOP: begin
               if (cur.stop_step == i2cseq_pkg::STEP_ISSUE) rsp.ctrl_cmd = i2cseq_pkg::CMD_STOP;
               rsp.done_res = (cur.stop_step == i2cseq_pkg::STEP_CHECK);
            end
            default: ;
         endcase
      end else begin
         unique case (cur.read_phase)
            i2cseq_pkg::RD_START: begin
               if (cur.start_step == i2cseq_pkg::STEP_ISSUE) rsp.ctrl_cmd = i2cseq_pkg::CMD_START;
            end
            i2cseq_pkg::RD_SLA_W: begin
               rsp.data_write_valid = 1'b1;
               rsp.data_value       = req.slave_addr_byte;
               if (cur.address_step == i2cseq_pkg::STEP_ISSUE)
                  rsp.ctrl_cmd = i2cseq_pkg::CMD_XFER;
            end
            i2cseq_pkg::RD_REG: begin
               rsp.data_write_valid = 1'b1;
               rsp.data_value       = req.reg_addr;
               if (cur.byte_step == i2cseq_pkg::STEP_ISSUE) rsp.ctrl_cmd = i2cseq_pkg::CMD_XFER;
            end
            i2cseq_pkg::RD_RESTART: begin
               if (cur.restart_step == i2cseq_pkg::STEP_ISSUE)
                  rsp.ctrl_cmd = i2cseq_pkg::CMD_START;
            end
            i2cseq_pkg::RD_SLA_R: begin
               rsp.data_write_valid = 1'b1;
               rsp.data_value       = sla_read;
               if (cur.address_step == i2cseq_pkg::STEP_ISSUE)
                  rsp.ctrl_cmd = i2cseq_pkg::CMD_XFER;
            end
            i2cseq_pkg::RD_RECEIVE: begin
               if (cur.receive_step == i2cseq_pkg::STEP_ISSUE)
                  rsp.ctrl_cmd = i2cseq_pkg::CMD_XFER;
               if (cur.receive_step == i2cseq_pkg::STEP_CAPTURE) begin
                  rsp.read_valid = 1'b1;
                  rsp.read_data  = req.rx_byte;
               end
            end
            i2cseq_pkg::RD_STOP: begin
               if (cur.stop_step == i2cseq_pkg::STEP_ISSUE) rsp.ctrl_cmd = i2cseq_pkg::CMD_STOP;
               rsp.done_res = (cur.stop_step == i2cseq_pkg::STEP_CHECK);
            end
            default: ;
         endcase
      end
   end

endmodule

// File: rtl/core/i2c_master_register_access_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access_sequencer
// poll-driven i2c register write / read sequencer for a byte-level controller
// ----------------------------------------------------------------------------
// Every req item is one poll of a register transaction (req_func 0 = write,
// 1 = read) together with the controller flags observed at that moment; every
// poll yields exactly one rsp item holding the control command to issue, an
// optional data register write, an optional captured receive byte and the
// done flag. A write runs start, slave address, register address, data byte,
// stop; a read runs start, slave address (write bit), register address,
// repeated start, slave address (read bit), receive without ack, stop. Each
// byte phase issues its command on its first poll, then waits for the
// interrupt flag, then compares the masked status; on a mismatch it keeps
// polling the compare step. One item is accepted per cycle while req_stall is
// low; each item is held in the input register, then moves into the result
// register once that register is free, and the phase registers are the only
// thing one poll hands to the next, updated in the same cycle the result is
// registered.
// ----------------------------------------------------------------------------
module i2c_master_register_access_sequencer (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_slave_addr_byte,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_write_data,
   input  logic       req_int_flag,
   input  logic       req_stop_pending,
   input  logic [7:0] req_status_reg,
   input  logic [7:0] req_rx_byte,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_ctrl_cmd,
   output logic       rsp_data_write_valid,
   output logic [7:0] rsp_data_value,
   output logic       rsp_done_res,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_data
);

   // input register
   logic                      in_valid_ff, in_valid_in;
   i2cseq_pkg::req_type       in_req_ff, in_req_in;

   // phase and sub-step registers carried from poll to poll
   i2cseq_pkg::seq_state_type state_ff, state_in;

   // result register
   logic                      out_valid_ff, out_valid_in;
   i2cseq_pkg::rsp_type       out_rsp_ff, out_rsp_in;

   i2cseq_pkg::seq_state_type poll_state;
   i2cseq_pkg::rsp_type       poll_rsp;
   i2cseq_pkg::req_type       req_bundle;

   logic out_free;    // result register can take a new item this cycle
   logic advance;     // the held poll moves into the result register
   logic req_accept;

   assign req_bundle = '{
      func:            req_func,
      slave_addr_byte: req_slave_addr_byte,
      reg_addr:        req_reg_addr,
      write_data:      req_write_data,
      int_flag:        req_int_flag,
      stop_pending:    req_stop_pending,
      status_reg:      req_status_reg,
      rx_byte:         req_rx_byte
   };

   // handshake: the input register refills while it drains
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   i2cseq_poll u_poll (
      .req (in_req_ff),
      .cur (state_ff),
      .nxt (poll_state),
      .rsp (poll_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_req_in   = in_req_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_req_in   = req_bundle;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (advance) begin
         state_in     = poll_state;
         out_valid_in = 1'b1;
         out_rsp_in   = poll_rsp;
      end else if (out_free) begin
         // result taken, nothing to replace it
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{
            write_phase:  i2cseq_pkg::WR_START,
            read_phase:   i2cseq_pkg::RD_START,
            start_step:   i2cseq_pkg::STEP_ISSUE,
            restart_step: i2cseq_pkg::STEP_ISSUE,
            address_step: i2cseq_pkg::STEP_ISSUE,
            byte_step:    i2cseq_pkg::STEP_ISSUE,
            receive_step: i2cseq_pkg::STEP_ISSUE,
            stop_step:    i2cseq_pkg::STEP_ISSUE
         };
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_ctrl_cmd         = out_rsp_ff.ctrl_cmd;
   assign rsp_data_write_valid = out_rsp_ff.data_write_valid;
   assign rsp_data_value       = out_rsp_ff.data_value;
   assign rsp_done_res         = out_rsp_ff.done_res;
   assign rsp_read_valid       = out_rsp_ff.read_valid;
   assign rsp_read_data        = out_rsp_ff.read_data;

   // a poll that leaves the input register always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("poll lost between input and result register");

   // input side only stalls while a poll is held
   a_stall_needs_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall without a held poll");

   // completion poll and receive capture never issue a command or a data write
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_rsp_ff.done_res || out_rsp_ff.read_valid)) |->
         (out_rsp_ff.ctrl_cmd == i2cseq_pkg::CMD_NONE && !out_rsp_ff.data_write_valid))
      else $error("done or capture poll also issued a command");

   // a stalled result holds its place
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_rsp_ff)))
      else $error("stalled result changed");

endmodule

// File: sim/i2cseq_poll_checker.sv
// ----------------------------------------------------------------------------
// i2cseq_poll_checker
// predicts every poll result of the i2c sequencer and compares it in order
// ----------------------------------------------------------------------------
module i2cseq_poll_checker
   import i2cseq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_slave_addr_byte,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_write_data,
   input  logic       req_int_flag,
   input  logic       req_stop_pending,
   input  logic [7:0] req_status_reg,
   input  logic [7:0] req_rx_byte,

   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_ctrl_cmd,
   input  logic       rsp_data_write_valid,
   input  logic [7:0] rsp_data_value,
   input  logic       rsp_done_res,
   input  logic       rsp_read_valid,
   input  logic [7:0] rsp_read_data,

   output int         errors,
   output int         pending
);

   seq_state_type seq;
   rsp_type       awaited_results[$];
   rsp_type       want;
   req_type       poll;
   int            results_seen;

   task automatic report(input string msg);
      if (errors < 40) $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   // issue, wait for the flag, compare the masked status
   function automatic logic byte_done(inout step_type step, input cmd_type cmd,
                                      input logic [7:0] code, input req_type q,
                                      inout rsp_type r);
      logic finished;
      finished = 1'b0;
      case (step)
         STEP_ISSUE: begin
            r.ctrl_cmd = cmd;
            step = STEP_WAIT;
         end
         STEP_WAIT: begin
            if (q.int_flag) step = STEP_CHECK;
         end
         STEP_CHECK: begin
            if ((q.status_reg & STATUS_MASK) == code) begin
               step = STEP_ISSUE;
               finished = 1'b1;
            end
         end
         default: step = STEP_ISSUE;
      endcase
      return finished;
   endfunction

   // data register is written on every poll of a send phase
   function automatic logic send_done(inout step_type step, input logic [7:0] value,
                                      input logic [7:0] code, input req_type q,
                                      inout rsp_type r);
      r.data_write_valid = 1'b1;
      r.data_value = value;
      return byte_done(step, CMD_XFER, code, q, r);
   endfunction

   function automatic logic stop_done(input req_type q, inout rsp_type r);
      logic finished;
      finished = 1'b0;
      case (seq.stop_step)
         STEP_ISSUE: begin
            r.ctrl_cmd = CMD_STOP;
            seq.stop_step = STEP_WAIT;
         end
         STEP_WAIT: begin
            if (!q.stop_pending) seq.stop_step = STEP_CHECK;
         end
         STEP_CHECK: begin
            seq.stop_step = STEP_ISSUE;
            finished = 1'b1;
         end
         default: seq.stop_step = STEP_ISSUE;
      endcase
      return finished;
   endfunction

   function automatic rsp_type predict_poll(input req_type q);
      rsp_type r;
      r = '0;
      if (!q.func) begin
         case (seq.write_phase)
            WR_START: begin
               if (byte_done(seq.start_step, CMD_START, ST_START, q, r))
                  seq.write_phase = WR_SLA;
            end
            WR_SLA: begin
               if (send_done(seq.address_step, q.slave_addr_byte, ST_MT_SLA_ACK, q, r))
                  seq.write_phase = WR_REG;
            end
            WR_REG: begin
               if (send_done(seq.byte_step, q.reg_addr, ST_MT_DATA_ACK, q, r))
                  seq.write_phase = WR_DATA;
            end
            WR_DATA: begin
               if (send_done(seq.byte_step, q.write_data, ST_MT_DATA_ACK, q, r))
                  seq.write_phase = WR_STOP;
            end
            WR_STOP: begin
               if (stop_done(q, r)) begin
                  seq.write_phase = WR_START;
                  r.done_res = 1'b1;
               end
            end
            default: ;
         endcase
      end else begin
         case (seq.read_phase)
            RD_START: begin
               if (byte_done(seq.start_step, CMD_START, ST_START, q, r))
                  seq.read_phase = RD_SLA_W;
            end
            RD_SLA_W: begin
               if (send_done(seq.address_step, q.slave_addr_byte, ST_MT_SLA_ACK, q, r))
                  seq.read_phase = RD_REG;
            end
            RD_REG: begin
               if (send_done(seq.byte_step, q.reg_addr, ST_MT_DATA_ACK, q, r))
                  seq.read_phase = RD_RESTART;
            end
            RD_RESTART: begin
               if (byte_done(seq.restart_step, CMD_START, ST_REP_START, q, r))
                  seq.read_phase = RD_SLA_R;
            end
            RD_SLA_R: begin
               // read bit added, address wraps at 8 bits
               if (send_done(seq.address_step, q.slave_addr_byte + 8'd1, ST_MR_SLA_ACK,
                             q, r))
                  seq.read_phase = RD_RECEIVE;
            end
            RD_RECEIVE: begin
               case (seq.receive_step)
                  STEP_ISSUE: begin
                     r.ctrl_cmd = CMD_XFER;
                     seq.receive_step = STEP_WAIT;
                  end
                  STEP_WAIT: begin
                     if (q.int_flag) seq.receive_step = STEP_CHECK;
                  end
                  STEP_CHECK: begin
                     if ((q.status_reg & STATUS_MASK) == ST_MR_DATA_NACK)
                        seq.receive_step = STEP_CAPTURE;
                  end
                  default: begin
                     r.read_valid = 1'b1;
                     r.read_data = q.rx_byte;
                     seq.receive_step = STEP_ISSUE;
                     seq.read_phase = RD_STOP;
                  end
               endcase
            end
            RD_STOP: begin
               if (stop_done(q, r)) begin
                  seq.read_phase = RD_START;
                  r.done_res = 1'b1;
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         seq = '0;
         awaited_results.delete();
         errors = 0;
         pending = 0;
         results_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report("result with no item waiting");
            end else begin
               want = awaited_results.pop_front();
               if (rsp_ctrl_cmd !== want.ctrl_cmd)
                  report($sformatf("result %0d ctrl_cmd %0d, want %0d",
                                   results_seen, rsp_ctrl_cmd, want.ctrl_cmd));
               if (rsp_data_write_valid !== want.data_write_valid)
                  report($sformatf("result %0d data_write_valid %0b, want %0b",
                                   results_seen, rsp_data_write_valid,
                                   want.data_write_valid));
               if (rsp_data_value !== want.data_value)
                  report($sformatf("result %0d data_value %02h, want %02h",
                                   results_seen, rsp_data_value, want.data_value));
               if (rsp_done_res !== want.done_res)
                  report($sformatf("result %0d done_res %0b, want %0b",
                                   results_seen, rsp_done_res, want.done_res));
               if (rsp_read_valid !== want.read_valid)
                  report($sformatf("result %0d read_valid %0b, want %0b",
                                   results_seen, rsp_read_valid, want.read_valid));
               if (rsp_read_data !== want.read_data)
                  report($sformatf("result %0d read_data %02h, want %02h",
                                   results_seen, rsp_read_data, want.read_data));
            end
            results_seen++;
         end
         if (req_valid && !req_stall) begin
            poll.func            = req_func;
            poll.slave_addr_byte = req_slave_addr_byte;
            poll.reg_addr        = req_reg_addr;
            poll.write_data      = req_write_data;
            poll.int_flag        = req_int_flag;
            poll.stop_pending    = req_stop_pending;
            poll.status_reg      = req_status_reg;
            poll.rx_byte         = req_rx_byte;
            awaited_results.push_back(predict_poll(poll));
         end
         pending = awaited_results.size();
      end
   end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the i2c register access sequencer
// ----------------------------------------------------------------------------
// Polls are generated as whole write and read transactions whose controller
// flags and status follow each phase (issue, flag wait, status compare with
// wrong codes first), so that the sequencer walks through every phase. A tail
// of noise polls and transactions cut short follows. A checker beside the
// block predicts and compares every result; both channel sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
   import i2cseq_pkg::*;

   logic       clock = 1'b0;
   logic       reset;

   logic       req_valid;
   logic       req_stall;
   logic       req_func;
   logic [7:0] req_slave_addr_byte;
   logic [7:0] req_reg_addr;
   logic [7:0] req_write_data;
   logic       req_int_flag;
   logic       req_stop_pending;
   logic [7:0] req_status_reg;
   logic [7:0] req_rx_byte;

   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_ctrl_cmd;
   logic       rsp_data_write_valid;
   logic [7:0] rsp_data_value;
   logic       rsp_done_res;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_data;

   int         errors;
   int         pending;

   // stimulus bookkeeping
   int         sent = 0;
   int         cut_left = -1;   // polls left before a transaction is cut, -1 = never
   bit         send_calm = 1'b0;
   bit         drained = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   i2c_master_register_access_sequencer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_slave_addr_byte  (req_slave_addr_byte),
      .req_reg_addr         (req_reg_addr),
      .req_write_data       (req_write_data),
      .req_int_flag         (req_int_flag),
      .req_stop_pending     (req_stop_pending),
      .req_status_reg       (req_status_reg),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_ctrl_cmd         (rsp_ctrl_cmd),
      .rsp_data_write_valid (rsp_data_write_valid),
      .rsp_data_value       (rsp_data_value),
      .rsp_done_res         (rsp_done_res),
      .rsp_read_valid       (rsp_read_valid),
      .rsp_read_data        (rsp_read_data)
   );

   i2cseq_poll_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_slave_addr_byte  (req_slave_addr_byte),
      .req_reg_addr         (req_reg_addr),
      .req_write_data       (req_write_data),
      .req_int_flag         (req_int_flag),
      .req_stop_pending     (req_stop_pending),
      .req_status_reg       (req_status_reg),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_ctrl_cmd         (rsp_ctrl_cmd),
      .rsp_data_write_valid (rsp_data_write_valid),
      .rsp_data_value       (rsp_data_value),
      .rsp_done_res         (rsp_done_res),
      .rsp_read_valid       (rsp_read_valid),
      .rsp_read_data        (rsp_read_data),
      .errors               (errors),
      .pending              (pending)
   );

   // half the time one of the controller's real codes, with random low bits
   function automatic logic [7:0] noisy_status();
      logic [7:0] c;
      case ($urandom_range(0, 5))
         0: c = ST_START;
         1: c = ST_REP_START;
         2: c = ST_MT_SLA_ACK;
         3: c = ST_MT_DATA_ACK;
         4: c = ST_MR_SLA_ACK;
         default: c = ST_MR_DATA_NACK;
      endcase
      if ($urandom_range(0, 1)) return c | 8'($urandom_range(0, 7));
      return 8'($urandom_range(0, 255));
   endfunction

   // random controller observations around a transaction's fixed fields
   function automatic req_type jitter(input req_type b, input bit any_func);
      req_type p;
      p = b;
      if (any_func) p.func = 1'($urandom_range(0, 1));
      p.int_flag     = 1'($urandom_range(0, 1));
      p.stop_pending = 1'($urandom_range(0, 1));
      p.status_reg   = noisy_status();
      p.rx_byte      = 8'($urandom_range(0, 255));
      return p;
   endfunction

   function automatic req_type fresh_base();
      req_type b;
      b = '0;
      b.func            = 1'($urandom_range(0, 1));
      b.slave_addr_byte = 8'($urandom_range(0, 254));
      b.reg_addr        = 8'($urandom_range(0, 255));
      b.write_data      = 8'($urandom_range(0, 255));
      return b;
   endfunction

   // one poll over the req channel; called and returns at a falling edge
   task automatic offer(input req_type p);
      int gap;
      if (cut_left == 0) return;
      if (cut_left > 0) cut_left--;
      // occasional stretches with no idling at all
      if (sent % 48 == 0) send_calm = ($urandom_range(0, 3) == 0);
      gap = send_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_func            <= p.func;
      req_slave_addr_byte <= p.slave_addr_byte;
      req_reg_addr        <= p.reg_addr;
      req_write_data      <= p.write_data;
      req_int_flag        <= p.int_flag;
      req_stop_pending    <= p.stop_pending;
      req_status_reg      <= p.status_reg;
      req_rx_byte         <= p.rx_byte;
      do @(posedge clock); while (req_stall);
      sent++;
      @(negedge clock);
   endtask

   // polls of one phase: issue, flag wait, status compare (or stop wait),
   // then the capture poll of a receive or the closing poll of a stop
   task automatic phase_polls(input req_type b, input logic [7:0] code,
                              input bit any_func, input bit is_stop, input bit capture,
                              input int waits, input int misses);
      req_type p;
      // issue poll, flags do not matter here
      offer(jitter(b, any_func));
      repeat (waits) begin
         p = jitter(b, any_func);
         if (is_stop) p.stop_pending = 1'b1;
         else p.int_flag = 1'b0;
         offer(p);
      end
      p = jitter(b, any_func);
      if (is_stop) p.stop_pending = 1'b0;
      else p.int_flag = 1'b1;
      offer(p);
      if (!is_stop) begin
         // wrong codes keep the block at its compare step
         repeat (misses) begin
            p = jitter(b, any_func);
            do p.status_reg = noisy_status();
            while ((p.status_reg & STATUS_MASK) == code);
            offer(p);
         end
         p = jitter(b, any_func);
         p.status_reg = code | 8'($urandom_range(0, 7));
         offer(p);
      end
      if (is_stop || capture) offer(jitter(b, any_func));
   endtask

   // a whole write or read; start-phase polls carry either func, since both
   // sides sit in their start phase between transactions and share the sub-step
   task automatic transaction(input req_type b, input int hi);
      phase_polls(b, ST_START, 1'b1, 1'b0, 1'b0, $urandom_range(0, hi), $urandom_range(0, hi));
      phase_polls(b, ST_MT_SLA_ACK, 1'b0, 1'b0, 1'b0, $urandom_range(0, hi),
                  $urandom_range(0, hi));
      phase_polls(b, ST_MT_DATA_ACK, 1'b0, 1'b0, 1'b0, $urandom_range(0, hi),
                  $urandom_range(0, hi));
      if (b.func) begin
         phase_polls(b, ST_REP_START, 1'b0, 1'b0, 1'b0, $urandom_range(0, hi),
                     $urandom_range(0, hi));
         phase_polls(b, ST_MR_SLA_ACK, 1'b0, 1'b0, 1'b0, $urandom_range(0, hi),
                     $urandom_range(0, hi));
         phase_polls(b, ST_MR_DATA_NACK, 1'b0, 1'b0, 1'b1, $urandom_range(0, hi),
                     $urandom_range(0, hi));
      end else begin
         phase_polls(b, ST_MT_DATA_ACK, 1'b0, 1'b0, 1'b0, $urandom_range(0, hi),
                     $urandom_range(0, hi));
      end
      // stop phase, no status code involved
      phase_polls(b, '0, 1'b0, 1'b1, 1'b0, $urandom_range(0, hi), 0);
   endtask

   // sender pause until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      wait (pending == 0);
      @(negedge clock);
   endtask

   // result side: random stalls, calm stretches and two long hold-offs
   initial begin
      int gap;
      int taken;
      bit calm;
      taken = 0;
      calm = 1'b0;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         gap = calm ? 0 : $urandom_range(0, 13);
         // long hold-off so the block fills up and stalls its input
         if (taken == 300 || taken == 900) gap = 240;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   // main stimulus and verdict
   initial begin
      req_type b;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_func            = 1'b0;
      req_slave_addr_byte = '0;
      req_reg_addr        = '0;
      req_write_data      = '0;
      req_int_flag        = 1'b0;
      req_stop_pending    = 1'b0;
      req_status_reg      = '0;
      req_rx_byte         = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: a read with top-end fields, the read bit takes address 254 to 255
      b = '0;
      b.func            = 1'b1;
      b.slave_addr_byte = 8'd254;
      b.reg_addr        = 8'd255;
      b.write_data      = 8'd255;
      transaction(b, 1);
      drain();

      // well-formed transactions with random content and timing
      while (sent < 1300) begin
         if (!drained && sent > 650) begin
            drain();
            drained = 1'b1;
         end
         transaction(fresh_base(), ($urandom_range(0, 7) == 0) ? 6 : 2);
      end

      // noise polls and transactions abandoned part way
      while (sent < 1550) begin
         if ($urandom_range(0, 1)) begin
            offer(jitter(fresh_base(), 1'b1));
         end else begin
            cut_left = $urandom_range(1, 30);
            transaction(fresh_base(), 3);
            cut_left = -1;
         end
      end

      drain();
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // hard limit on the run
   initial begin
      #6000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/i2cseq_pkg.sv
rtl/core/i2cseq_poll.sv
rtl/core/i2c_master_register_access_sequencer.sv
sim/i2cseq_poll_checker.sv
sim/tb_top.sv
